>>> rtl/lcdrp_pkg.sv
// Shared constants, codes and colour helpers for the LCD register and palette unit.
`timescale 1ns / 1ps

package lcdrp_pkg;

    localparam int PAL_BYTES    = 64;
    localparam int PAL_ROWS     = PAL_BYTES / 2;
    localparam int PAL_AW       = $clog2(PAL_BYTES);
    localparam int PAL_RW       = $clog2(PAL_ROWS);
    localparam int LCD_REG_NUM  = 12;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_STATUS = 3'd2;
    localparam logic [2:0] OP_BG     = 3'd3;
    localparam logic [2:0] OP_OBJ    = 3'd4;

    localparam logic        CFG_COLOUR_MODE = 1'b0;
    localparam logic        CFG_DMG_COLOUR  = 1'b1;

    localparam logic [3:0] REG_LCDC = 4'd0;
    localparam logic [3:0] REG_STAT = 4'd1;
    localparam logic [3:0] REG_LY   = 4'd4;
    localparam logic [3:0] REG_LYC  = 4'd5;
    localparam logic [3:0] REG_BGP  = 4'd7;
    localparam logic [3:0] REG_OBP0 = 4'd8;
    localparam logic [3:0] REG_OBP1 = 4'd9;
    localparam logic [3:0] REG_LAST = 4'd11;

    localparam logic [11:0] ADDR_LCD_PAGE = 12'hFF4;
    localparam logic [15:0] ADDR_LCDC     = 16'hFF40;
    localparam logic [15:0] ADDR_STAT     = 16'hFF41;
    localparam logic [15:0] ADDR_LY       = 16'hFF44;
    localparam logic [15:0] ADDR_LYC      = 16'hFF45;
    localparam logic [15:0] ADDR_BGPI     = 16'hFF68;
    localparam logic [15:0] ADDR_BGPD     = 16'hFF69;
    localparam logic [15:0] ADDR_OBPI     = 16'hFF6A;
    localparam logic [15:0] ADDR_OBPD     = 16'hFF6B;
    localparam logic [15:0] ADDR_OPRI     = 16'hFF6C;

    localparam logic [7:0] STAT_WR_MASK = 8'h78;
    localparam logic [7:0] PTR_WR_MASK  = 8'hBF;
    localparam logic [7:0] PTR_RD_SET   = 8'h40;
    localparam logic [7:0] BYTE_OPEN    = 8'hFF;
    localparam logic [7:0] ALPHA        = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    function automatic logic [7:0] lcd_reg_reset(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            REG_LCDC: v = 8'h91;
            REG_STAT: v = 8'h80;
            REG_BGP:  v = 8'hFC;
            REG_OBP0: v = 8'hFF;
            REG_OBP1: v = 8'hFF;
            default:  v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] idx);
        logic [1:0] s;
        unique case (idx)
            2'd0:    s = pal[1:0];
            2'd1:    s = pal[3:2];
            2'd2:    s = pal[5:4];
            default: s = pal[7:6];
        endcase
        return s;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [31:0] rgb_to_argb(input logic [15:0] rgb);
        return {ALPHA, widen5(rgb[14:10]), widen5(rgb[9:5]), widen5(rgb[4:0])};
    endfunction

    function automatic logic [31:0] mono_argb(input logic [1:0] s);
        logic [7:0] m;
        unique case (s)
            2'd0:    m = 8'hFF;
            2'd1:    m = 8'hAA;
            2'd2:    m = 8'h55;
            default: m = 8'h00;
        endcase
        return {ALPHA, m, m, m};
    endfunction

endpackage

>>> rtl/lcdrp_pal_mem.sv
// Colour palette memory: byte writes, two-byte row reads, per-byte valid bits.
`timescale 1ns / 1ps

module lcdrp_pal_mem
    import lcdrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [PAL_RW-1:0]   i_rd_row,
    input  logic                i_we,
    input  logic [PAL_AW-1:0]   i_wr_addr,
    input  logic [7:0]          i_wr_data,
    output logic [15:0]         o_rd_data
);

    logic [7:0]          r_mem_lo [PAL_ROWS];
    logic [7:0]          r_mem_hi [PAL_ROWS];
    logic [PAL_ROWS-1:0] r_vld_lo;
    logic [PAL_ROWS-1:0] r_vld_hi;
    logic [7:0]          r_rd_lo;
    logic [7:0]          r_rd_hi;
    logic                r_rd_vld_lo;
    logic                r_rd_vld_hi;
    logic [PAL_RW-1:0]   wr_row;

    assign wr_row = i_wr_addr[PAL_AW-1:1];

    always_ff @(posedge i_clk) begin
        if (i_we && !i_wr_addr[0]) begin
            r_mem_lo[wr_row] <= i_wr_data;
        end
        if (i_we && i_wr_addr[0]) begin
            r_mem_hi[wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_lo     <= r_mem_lo[i_rd_row];
            r_rd_hi     <= r_mem_hi[i_rd_row];
            r_rd_vld_lo <= r_vld_lo[i_rd_row];
            r_rd_vld_hi <= r_vld_hi[i_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_lo <= '0;
            r_vld_hi <= '0;
        end else if (i_we) begin
            if (i_wr_addr[0]) begin
                r_vld_hi[wr_row] <= 1'b1;
            end else begin
                r_vld_lo[wr_row] <= 1'b1;
            end
        end
    end

    assign o_rd_data = {r_rd_vld_hi ? r_rd_hi : BYTE_OPEN,
                        r_rd_vld_lo ? r_rd_lo : BYTE_OPEN};

endmodule

>>> rtl/lcd_register_and_palette_unit.sv
// Top level: LCD registers, palette index logic, bus decode and colour lookup.
//
//  channel | signals                         | beat taken when
//  in      | i_valid / o_ready, i_opcode ... | i_valid & o_ready
//  out     | o_valid / i_ready, o_read_data..| o_valid & i_ready
//  config  | i_cfg_we, i_cfg_index, i_cfg_data | i_cfg_we
//
//  An item's palette row is read at accept; the result and write-back follow in
//  the busy state, from the registered read data of the palette memories.
//  The finished beat sits in the output register; a new item is taken meanwhile,
//  and waits in the busy state while the output register is still full.
//  Reset is synchronous and needs no clearing pass: valid bits mark written bytes.
`timescale 1ns / 1ps

module lcd_register_and_palette_unit
    import lcdrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_lcd_mode,
    input  logic [7:0]  i_line_number,
    input  logic        i_do_compare,
    input  logic        i_suppress_match,
    input  logic [2:0]  i_palette_number,
    input  logic [1:0]  i_colour_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic [31:0] o_pixel_argb,
    output logic        o_enable_changed,
    output logic        o_stat_update
);

    t_state            r_state, n_state;
    logic              r_colour_mode;
    logic              r_dmg_colourise;
    logic [7:0]        r_lcd_regs [LCD_REG_NUM];
    logic [7:0]        n_lcd_regs [LCD_REG_NUM];
    logic [7:0]        r_bg_ptr, n_bg_ptr;
    logic [7:0]        r_obj_ptr, n_obj_ptr;
    logic              r_prio, n_prio;

    logic [2:0]        r_op;
    logic [15:0]       r_addr;
    logic [7:0]        r_wdata;
    logic [1:0]        r_mode;
    logic [7:0]        r_line;
    logic              r_cmp;
    logic              r_supp;
    logic [2:0]        r_pal;
    logic [1:0]        r_idx;

    logic              r_out_valid;
    logic [7:0]        r_read_data, n_read_data;
    logic [31:0]       r_pixel, n_pixel;
    logic              r_en_chg, n_en_chg;
    logic              r_stat_upd, n_stat_upd;

    logic              accept;
    logic              fin;
    logic              blocked;
    logic              reg_hit;
    logic [7:0]        obp_in, obp_r;
    logic [1:0]        shade_bg_in, shade_obj_in;
    logic [1:0]        shade_r;
    logic [PAL_RW-1:0] bg_row, obj_row;
    logic [15:0]       bg_rd, obj_rd;
    logic              bg_we, obj_we;
    logic [7:0]        bg_byte, obj_byte;
    logic [2:0]        co;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign fin     = (r_state == S_BUSY) && (!r_out_valid || i_ready);

    assign blocked = r_lcd_regs[REG_LCDC][7] && (r_lcd_regs[REG_STAT][1:0] == 2'd3);
    assign reg_hit = (r_addr[15:4] == ADDR_LCD_PAGE) && (r_addr[3:0] <= REG_LAST);

    assign obp_in       = i_palette_number[0] ? r_lcd_regs[REG_OBP1] : r_lcd_regs[REG_OBP0];
    assign shade_bg_in  = shade_of(r_lcd_regs[REG_BGP], i_colour_index);
    assign shade_obj_in = shade_of(obp_in, i_colour_index);

    always_comb begin
        if (i_opcode == OP_BG) begin
            bg_row = r_colour_mode ? {i_palette_number, i_colour_index}
                                   : {3'd0, shade_bg_in};
        end else begin
            bg_row = r_bg_ptr[PAL_AW-1:1];
        end
        if (i_opcode == OP_OBJ) begin
            obj_row = r_colour_mode ? {i_palette_number, i_colour_index}
                                    : {2'd0, i_palette_number[0], shade_obj_in};
        end else begin
            obj_row = r_obj_ptr[PAL_AW-1:1];
        end
    end

    lcdrp_pal_mem u_bg_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_row  (bg_row),
        .i_we      (bg_we),
        .i_wr_addr (r_bg_ptr[PAL_AW-1:0]),
        .i_wr_data (r_wdata),
        .o_rd_data (bg_rd)
    );

    lcdrp_pal_mem u_obj_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_row  (obj_row),
        .i_we      (obj_we),
        .i_wr_addr (r_obj_ptr[PAL_AW-1:0]),
        .i_wr_data (r_wdata),
        .o_rd_data (obj_rd)
    );

    assign bg_byte  = r_bg_ptr[0]  ? bg_rd[15:8]  : bg_rd[7:0];
    assign obj_byte = r_obj_ptr[0] ? obj_rd[15:8] : obj_rd[7:0];
    assign obp_r    = r_pal[0] ? r_lcd_regs[REG_OBP1] : r_lcd_regs[REG_OBP0];
    assign shade_r  = shade_of((r_op == OP_BG) ? r_lcd_regs[REG_BGP] : obp_r, r_idx);

    always_comb begin
        n_state     = r_state;
        n_lcd_regs  = r_lcd_regs;
        n_bg_ptr    = r_bg_ptr;
        n_obj_ptr   = r_obj_ptr;
        n_prio      = r_prio;
        n_read_data = 8'h00;
        n_pixel     = 32'h0;
        n_en_chg    = 1'b0;
        n_stat_upd  = 1'b0;
        bg_we       = 1'b0;
        obj_we      = 1'b0;
        co          = 3'd0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        case (r_op)
            OP_READ: begin
                if (reg_hit) begin
                    n_read_data = r_lcd_regs[r_addr[3:0]];
                end else if (!r_colour_mode) begin
                    n_read_data = BYTE_OPEN;
                end else begin
                    case (r_addr)
                        ADDR_BGPI: n_read_data = r_bg_ptr | PTR_RD_SET;
                        ADDR_OBPI: n_read_data = r_obj_ptr | PTR_RD_SET;
                        ADDR_BGPD: n_read_data = blocked ? BYTE_OPEN : bg_byte;
                        ADDR_OBPD: n_read_data = blocked ? BYTE_OPEN : obj_byte;
                        ADDR_OPRI: n_read_data = {7'h7F, r_prio};
                        default:   n_read_data = BYTE_OPEN;
                    endcase
                end
            end
            OP_WRITE: begin
                if (reg_hit) begin
                    if (r_addr == ADDR_STAT) begin
                        n_lcd_regs[REG_STAT] = 8'h80 | (r_wdata & STAT_WR_MASK)
                                             | {5'd0, r_lcd_regs[REG_STAT][2:0]};
                    end else if (r_addr != ADDR_LY) begin
                        n_lcd_regs[r_addr[3:0]] = r_wdata;
                    end
                    n_en_chg   = fin && (r_addr == ADDR_LCDC)
                                 && (r_wdata[7] != r_lcd_regs[REG_LCDC][7]);
                    n_stat_upd = (r_addr == ADDR_STAT) || (r_addr == ADDR_LYC);
                end else if (r_colour_mode) begin
                    case (r_addr)
                        ADDR_BGPI: n_bg_ptr  = r_wdata & PTR_WR_MASK;
                        ADDR_OBPI: n_obj_ptr = r_wdata & PTR_WR_MASK;
                        ADDR_BGPD: begin
                            bg_we = fin && !blocked;
                            if (r_bg_ptr[7]) begin
                                n_bg_ptr = {2'b10, r_bg_ptr[5:0] + 6'd1};
                            end
                        end
                        ADDR_OBPD: begin
                            obj_we = fin && !blocked;
                            if (r_obj_ptr[7]) begin
                                n_obj_ptr = {2'b10, r_obj_ptr[5:0] + 6'd1};
                            end
                        end
                        ADDR_OPRI: n_prio = r_wdata[0];
                        default: ;
                    endcase
                end
            end
            OP_STATUS: begin
                n_lcd_regs[REG_LY] = r_line;
                if (r_cmp) begin
                    co = (r_line == r_lcd_regs[REG_LYC]) ? 3'd4 : 3'd0;
                end else begin
                    co = {r_lcd_regs[REG_STAT][2], 2'd0};
                end
                if (r_supp) begin
                    co = 3'd0;
                end
                n_lcd_regs[REG_STAT] = {r_lcd_regs[REG_STAT][7:3], co[2], r_mode};
            end
            OP_BG: begin
                n_pixel = (r_colour_mode || r_dmg_colourise) ? rgb_to_argb(bg_rd)
                                                             : mono_argb(shade_r);
            end
            OP_OBJ: begin
                n_pixel = (r_colour_mode || r_dmg_colourise) ? rgb_to_argb(obj_rd)
                                                             : mono_argb(shade_r);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_colour_mode   <= 1'b0;
            r_dmg_colourise <= 1'b0;
            r_bg_ptr        <= 8'h00;
            r_obj_ptr       <= 8'h00;
            r_prio          <= 1'b0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < LCD_REG_NUM; i++) begin
                r_lcd_regs[i] <= lcd_reg_reset(4'(i));
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_index == CFG_COLOUR_MODE)) begin
                r_colour_mode <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_DMG_COLOUR)) begin
                r_dmg_colourise <= i_cfg_data;
            end
            if (fin) begin
                r_lcd_regs  <= n_lcd_regs;
                r_bg_ptr    <= n_bg_ptr;
                r_obj_ptr   <= n_obj_ptr;
                r_prio      <= n_prio;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_mode  <= i_lcd_mode;
            r_line  <= i_line_number;
            r_cmp   <= i_do_compare;
            r_supp  <= i_suppress_match;
            r_pal   <= i_palette_number;
            r_idx   <= i_colour_index;
        end
        if (fin) begin
            r_read_data <= n_read_data;
            r_pixel     <= n_pixel;
            r_en_chg    <= n_en_chg;
            r_stat_upd  <= n_stat_upd;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_data      = r_read_data;
    assign o_pixel_argb     = r_pixel;
    assign o_enable_changed = r_en_chg;
    assign o_stat_update    = r_stat_upd;

endmodule
